>>> design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock, masked while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/ppid_pkg.sv
package ppid_pkg;

  // sample and fixed point format
  localparam int SAMPLE_WIDTH = 24;
  localparam int FRAC_BITS    = 16;

  // register field widths
  localparam int GAIN_W  = 32;
  localparam int LIMIT_W = 31;
  localparam int DB_W    = 24;
  localparam int PER_W   = 24;
  localparam logic [PER_W-1:0] WRAP_PERIOD_RESET = PER_W'(129144);

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // datapath widths
  localparam int ERR_W   = SAMPLE_WIDTH + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int DRIVE_W = 32;
  localparam int WK_W    = ((ERR_W > PER_W + 1) ? ERR_W : PER_W + 1) + 2;
  localparam int PROD_W  = DIFF_W + GAIN_W + 1;
  localparam int EXT_W   = (PROD_W > 63) ? PROD_W : 63;
  localparam int SUM_W   = 64;
  localparam int ACC_W   = LIMIT_W + FRAC_BITS + 1;

  // stream payload widths, rounded up to bytes
  localparam int IN_DATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((DRIVE_W + ERR_W + 7) / 8) * 8;

  // register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_DRIVE_LIMIT    = 3'd4,
    REG_DEAD_BAND      = 3'd5,
    REG_WRAP_ENABLE    = 3'd6,
    REG_WRAP_PERIOD    = 3'd7
  } cfg_reg_t;

  // product saturation bound, 2^61
  localparam logic signed [EXT_W-1:0] PROD_SAT = {{(EXT_W-62){1'b0}}, 1'b1, 61'd0};

  // saturate a gain product to +/- 2^61
  function automatic logic signed [SUM_W-1:0] sat_prod(input logic signed [PROD_W-1:0] p);
    logic signed [EXT_W-1:0] ext;
    logic signed [EXT_W-1:0] res;
    ext = EXT_W'(p);
    if (ext > PROD_SAT) begin
      res = PROD_SAT;
    end else if (ext < -PROD_SAT) begin
      res = -PROD_SAT;
    end else begin
      res = ext;
    end
    return SUM_W'(res);
  endfunction

endpackage

>>> design/positional_pid_deadzone_wrap.sv
// positional pid with deadzone, angle wrap, integral and drive clamps
// each beat passes through stages s0 to s5 and the output register
// throughput: one beat per cycle; seven register stages, each stalls only
//   when it is full and the stage after it cannot take its beat
// reset (rst, synchronous): empties the pipeline, clears stored error and
//   integral, loads register defaults (wrap period 129144, all others 0)
module positional_pid_deadzone_wrap
  import ppid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // setpoint, measured
  input  logic                  s_tuser,   // action (1 clears)
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // drive, error_seen
);

  // configuration registers
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  integ_gain;
  logic [GAIN_W-1:0]  deriv_gain;
  logic [LIMIT_W-1:0] integral_limit;
  logic [LIMIT_W-1:0] drive_limit;
  logic [DB_W-1:0]    dead_band;
  logic               wrap_enable;
  logic [PER_W-1:0]   wrap_period;

  // controller state
  logic signed [ERR_W-1:0] prev_error;
  logic signed [ACC_W-1:0] integral_acc;

  // pipeline control
  logic [6:0] valid;
  logic [6:0] rdy;

  // stage registers
  logic                     s0_clr;
  logic signed [SAMPLE_WIDTH-1:0] s0_sp;
  logic signed [SAMPLE_WIDTH-1:0] s0_ms;
  logic                     s1_clr;
  logic signed [ERR_W-1:0]  s1_err;
  logic                     s2_clr;
  logic signed [ERR_W-1:0]  s2_err;
  logic                     s3_clr;
  logic signed [ERR_W-1:0]  s3_err;
  logic signed [DIFF_W-1:0] s3_diff;
  logic                     s4_clr;
  logic signed [ERR_W-1:0]  s4_err;
  logic signed [PROD_W-1:0] s4_pd;
  logic signed [PROD_W-1:0] s4_pp;
  logic signed [PROD_W-1:0] s4_pi;
  logic                     s5_clr;
  logic signed [ERR_W-1:0]  s5_err;
  logic signed [SUM_W-1:0]  s5_pdp;
  logic signed [ACC_W-1:0]  s5_acc;
  logic signed [DRIVE_W-1:0] m_drive;
  logic signed [ERR_W-1:0]  m_err;

  // combinational stage logic
  logic signed [WK_W-1:0]   raw1;
  logic signed [WK_W-1:0]   mag1;
  logic signed [WK_W-1:0]   db1;
  logic signed [WK_W-1:0]   e2;
  logic signed [WK_W-1:0]   per2;
  logic signed [WK_W-1:0]   half2;
  logic signed [WK_W-1:0]   fold2;
  logic signed [WK_W-1:0]   clamp2;
  logic signed [DIFF_W-1:0] diff3;
  logic signed [PROD_W-1:0] pd4;
  logic signed [PROD_W-1:0] pp4;
  logic signed [PROD_W-1:0] pi4;
  logic signed [SUM_W-1:0]  pi5;
  logic signed [SUM_W-1:0]  acc_sum5;
  logic signed [SUM_W-1:0]  ilim5;
  logic signed [SUM_W-1:0]  acc_cl5;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [SUM_W-1:0]  pdp5;
  logic signed [SUM_W-1:0]  sum6;
  logic signed [SUM_W-1:0]  fl6;
  logic signed [SUM_W-1:0]  dlim6;
  logic signed [SUM_W-1:0]  cl6;
  logic signed [DRIVE_W-1:0] drive_next;

  localparam logic signed [WK_W-1:0] ERR_MAX_W =
    WK_W'((64'd1 << SAMPLE_WIDTH) - 64'd1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= '0;
      integ_gain     <= '0;
      deriv_gain     <= '0;
      integral_limit <= '0;
      drive_limit    <= '0;
      dead_band      <= '0;
      wrap_enable    <= 1'b0;
      wrap_period    <= WRAP_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PROP_GAIN:      prop_gain      <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_GAIN:     integ_gain     <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN:     deriv_gain     <= cfg_wdata[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_DRIVE_LIMIT:    drive_limit    <= cfg_wdata[LIMIT_W-1:0];
        REG_DEAD_BAND:      dead_band      <= cfg_wdata[DB_W-1:0];
        REG_WRAP_ENABLE:    wrap_enable    <= cfg_wdata[0];
        REG_WRAP_PERIOD:    wrap_period    <= cfg_wdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // stage ready chain, a stage moves when empty or its successor moves
  always_comb begin
    rdy[6] = !valid[6] || m_tready;
    for (int k = 5; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = valid[6];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (rdy[0]) valid[0] <= s_tvalid;
      for (int k = 1; k < 7; k++) begin
        if (rdy[k]) valid[k] <= valid[k-1];
      end
    end
  end

  // stage 1: raw error and deadzone
  always_comb begin
    raw1 = WK_W'(s0_sp) - WK_W'(s0_ms);
    mag1 = raw1[WK_W-1] ? -raw1 : raw1;
    db1  = $signed(WK_W'(dead_band));
  end

  // stage 2: wrap fold and error range clamp
  always_comb begin
    e2    = WK_W'(s1_err);
    per2  = $signed(WK_W'(wrap_period));
    half2 = per2 >>> 1;
    fold2 = e2;
    if (wrap_enable) begin
      if (e2 > half2) begin
        fold2 = e2 - per2;
      end else if (e2 < -half2) begin
        fold2 = e2 + per2;
      end
    end
    if (fold2 > ERR_MAX_W) begin
      clamp2 = ERR_MAX_W;
    end else if (fold2 < -ERR_MAX_W) begin
      clamp2 = -ERR_MAX_W;
    end else begin
      clamp2 = fold2;
    end
  end

  // stage 3: error difference against the previous step
  assign diff3 = DIFF_W'(s2_err) - DIFF_W'(prev_error);

  // stage 4: gain products
  assign pd4 = s3_diff * $signed({1'b0, deriv_gain});
  assign pp4 = s3_err * $signed({1'b0, prop_gain});
  assign pi4 = s3_err * $signed({1'b0, integ_gain});

  // stage 5: integral update and clamp, p plus d
  always_comb begin
    pi5      = sat_prod(s4_pi);
    ilim5    = SUM_W'({integral_limit, {FRAC_BITS{1'b0}}});
    acc_sum5 = SUM_W'(integral_acc) + pi5;
    if (acc_sum5 > ilim5) begin
      acc_cl5 = ilim5;
    end else if (acc_sum5 < -ilim5) begin
      acc_cl5 = -ilim5;
    end else begin
      acc_cl5 = acc_sum5;
    end
    acc_next = s4_clr ? '0 : acc_cl5[ACC_W-1:0];
    pdp5     = sat_prod(s4_pd) + sat_prod(s4_pp);
  end

  // stage 6: total, floor and drive clamp
  always_comb begin
    sum6  = s5_pdp + SUM_W'(s5_acc);
    fl6   = sum6 >>> FRAC_BITS;
    dlim6 = SUM_W'(drive_limit);
    if (fl6 > dlim6) begin
      cl6 = dlim6;
    end else if (fl6 < -dlim6) begin
      cl6 = -dlim6;
    end else begin
      cl6 = fl6;
    end
    drive_next = s5_clr ? '0 : cl6[DRIVE_W-1:0];
  end

  // controller state, updated in beat order
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error   <= '0;
      integral_acc <= '0;
    end else begin
      if (rdy[3] && valid[2]) prev_error <= s2_err;
      if (rdy[5] && valid[4]) integral_acc <= acc_next;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_clr <= s_tuser;
      s0_sp  <= s_tdata[SAMPLE_WIDTH-1:0];
      s0_ms  <= s_tdata[2*SAMPLE_WIDTH-1 -: SAMPLE_WIDTH];
    end
    if (rdy[1]) begin
      s1_clr <= s0_clr;
      s1_err <= (s0_clr || mag1 < db1) ? '0 : raw1[ERR_W-1:0];
    end
    if (rdy[2]) begin
      s2_clr <= s1_clr;
      s2_err <= clamp2[ERR_W-1:0];
    end
    if (rdy[3]) begin
      s3_clr  <= s2_clr;
      s3_err  <= s2_err;
      s3_diff <= diff3;
    end
    if (rdy[4]) begin
      s4_clr <= s3_clr;
      s4_err <= s3_err;
      s4_pd  <= pd4;
      s4_pp  <= pp4;
      s4_pi  <= pi4;
    end
    if (rdy[5]) begin
      s5_clr <= s4_clr;
      s5_err <= s4_err;
      s5_pdp <= pdp5;
      s5_acc <= acc_next;
    end
    if (rdy[6]) begin
      m_drive <= drive_next;
      m_err   <= s5_err;
    end
  end

  assign m_tdata = OUT_DATA_W'({m_err, m_drive});

endmodule

>>> design/ppid_checker.sv
`include "assert_macros.svh"

module ppid_checker
  import ppid_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  localparam logic [ERR_W-1:0]   ERR_MIN   = {1'b1, {SAMPLE_WIDTH{1'b0}}};
  localparam logic [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  logic [ERR_W-1:0]   err_out;
  logic [DRIVE_W-1:0] drive_out;
  logic               stalled;

  assign err_out   = m_tdata[DRIVE_W +: ERR_W];
  assign drive_out = m_tdata[DRIVE_W-1:0];
  assign stalled   = m_tvalid && !m_tready;

  // a stalled result beat holds
  `ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
  // an empty output means the whole pipeline can take a beat
  `ASSERT_CLK(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")
  // pipeline comes out of reset empty
  `ASSERT_CLK(a_reset_empty, $past(rst) |-> !m_tvalid, "result beat right after reset")
  // error stays inside its symmetric range
  `ASSERT_CLK(a_err_range, m_tvalid |-> err_out != ERR_MIN, "error outside symmetric range")
  // drive clamp is symmetric, most negative code never appears
  `ASSERT_CLK(a_drive_range, m_tvalid |-> drive_out != DRIVE_MIN, "drive outside clamp range")

endmodule

bind positional_pid_deadzone_wrap ppid_checker u_ppid_checker (.*);

>>> dv/tb_positional_pid_deadzone_wrap.sv
`timescale 1ns / 1ps

module tb_positional_pid_deadzone_wrap;
  import ppid_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 66;
  localparam int HOLD_AFTER_ITEMS = 200;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 12;
  localparam longint PRODUCT_BOUND = longint'(1) <<< 61;
  localparam longint ERR_BOUND = (longint'(1) <<< SAMPLE_WIDTH) - 1;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [ERR_W-1:0]   err;
  } pid_result_t;

  typedef struct packed {
    bit [31:0] prop_gain;
    bit [31:0] integ_gain;
    bit [31:0] deriv_gain;
    bit [31:0] integral_limit;
    bit [31:0] drive_limit;
    bit [31:0] dead_band;
    bit [31:0] wrap_enable;
    bit [31:0] wrap_period;
  } pid_cfg_t;

  // typed result, used only where the row carries one
  typedef struct packed {
    bit          typed;
    pid_result_t res;
  } known_result_t;

  typedef struct {
    int cfg_sel;
    bit action;
    int setpoint;
    int measured;
    bit typed;
    int exp_drive;
    int exp_err;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // setpoint, measured
  logic                  s_tuser;   // action (1 clears)
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // drive, error_seen

  positional_pid_deadzone_wrap dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  wire in_beat  = s_tvalid && s_tready;
  wire out_beat = m_tvalid && m_tready;

  pid_cfg_t      active_cfg;
  longint        tracked_error;
  longint        integral_q16;
  pid_result_t   expected_results[$];
  known_result_t known_results[$];
  int            fail_count;
  int            items_taken;
  int            idle_cycles;
  int            burst_left;
  stim_row_t     dir_rows[24];

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // signed value times unsigned q16.16 gain, saturated
  function automatic longint gain_mul(longint e, bit [31:0] g);
    return clip(e * longint'(g), PRODUCT_BOUND);
  endfunction

  // one control step on the testbench copy of the controller state
  function automatic pid_result_t pid_step(bit clear, logic signed [SAMPLE_WIDTH-1:0] sp,
                                           logic signed [SAMPLE_WIDTH-1:0] ms);
    longint raw;
    longint mag;
    longint e;
    longint per;
    longint half;
    longint sum;
    longint out;
    pid_result_t r;
    if (clear) begin
      tracked_error = 0;
      integral_q16 = 0;
      r.drive = '0;
      r.err = '0;
      return r;
    end
    raw = longint'(sp) - longint'(ms);
    mag = (raw < 0) ? -raw : raw;
    e = (mag < longint'(active_cfg.dead_band)) ? 0 : raw;
    // single fold into about half a period either side
    if (active_cfg.wrap_enable[0]) begin
      per = longint'(active_cfg.wrap_period);
      half = per / 2;
      if (e > half) begin
        e = e - per;
      end else if (e < -half) begin
        e = e + per;
      end
    end
    e = clip(e, ERR_BOUND);
    sum = gain_mul(e - tracked_error, active_cfg.deriv_gain)
        + gain_mul(e, active_cfg.prop_gain);
    integral_q16 = clip(integral_q16 + gain_mul(e, active_cfg.integ_gain),
                        longint'(active_cfg.integral_limit) <<< FRAC_BITS);
    sum = sum + integral_q16;
    // arithmetic shift floors toward minus infinity
    out = clip(sum >>> FRAC_BITS, longint'(active_cfg.drive_limit));
    tracked_error = e;
    r.drive = out[DRIVE_W-1:0];
    r.err = e[ERR_W-1:0];
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, bit [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(pid_cfg_t c);
    write_reg(REG_PROP_GAIN, c.prop_gain);
    write_reg(REG_INTEG_GAIN, c.integ_gain);
    write_reg(REG_DERIV_GAIN, c.deriv_gain);
    write_reg(REG_INTEGRAL_LIMIT, c.integral_limit);
    write_reg(REG_DRIVE_LIMIT, c.drive_limit);
    write_reg(REG_DEAD_BAND, c.dead_band);
    write_reg(REG_WRAP_ENABLE, c.wrap_enable);
    write_reg(REG_WRAP_PERIOD, c.wrap_period);
    cfg_we <= 1'b0;
    c.integral_limit &= 32'h7FFF_FFFF;
    c.drive_limit &= 32'h7FFF_FFFF;
    c.dead_band &= 32'h00FF_FFFF;
    c.wrap_enable &= 32'h1;
    c.wrap_period &= 32'h00FF_FFFF;
    active_cfg = c;
  endtask

  // wait for every result, then let the pipeline settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0 || known_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // offer one beat, then maybe leave a gap before the next burst
  task automatic offer(bit act, logic [SAMPLE_WIDTH-1:0] sp, logic [SAMPLE_WIDTH-1:0] ms,
                       known_result_t known);
    known_results.push_back(known);
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= IN_DATA_W'({ms, sp});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  function automatic bit [31:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1, 2: return $urandom_range(0, 32'h0003_0000);
      3: return $urandom;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic bit [31:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1, 2: return $urandom_range(0, 20000);
      3: return $urandom & 32'h7FFF_FFFF;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // predict each accepted input beat
  always @(posedge clk) begin : predict_inputs
    known_result_t k;
    pid_result_t p;
    if (!rst && in_beat) begin
      k = known_results.pop_front();
      p = pid_step(s_tuser, s_tdata[SAMPLE_WIDTH-1:0], s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
      expected_results.push_back(k.typed ? k.res : p);
      items_taken <= items_taken + 1;
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    pid_result_t want;
    logic signed [DRIVE_W-1:0] got_drive;
    logic signed [ERR_W-1:0] got_err;
    if (!rst && out_beat) begin
      got_drive = m_tdata[DRIVE_W-1:0];
      got_err = m_tdata[DRIVE_W +: ERR_W];
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: drive %0d error_seen %0d",
               got_drive, got_err);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got_drive !== want.drive) begin
          $error("drive mismatch: expected %0d, got %0d", want.drive, got_drive);
          fail_count++;
        end
        if (got_err !== want.err) begin
          $error("error_seen mismatch: expected %0d, got %0d", want.err, got_err);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || in_beat || out_beat) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_positional_pid_deadzone_wrap failed");
      $finish;
    end
  end

  // receiver: stall pattern re-picked at random, one long hold-off
  initial begin : result_sink
    int mode;
    int cnt;
    bit held;
    m_tready = 1'b0;
    mode = 0;
    cnt = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && items_taken >= HOLD_AFTER_ITEMS) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      cnt++;
      if (cnt % 32 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= cnt[0];
      endcase
    end
  end

  initial begin : stimulus
    pid_cfg_t c;
    known_result_t k;
    int cur_sel;
    int sp;
    int ms;
    int delta;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = REG_PROP_GAIN;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    fail_count = 0;
    items_taken = 0;
    idle_cycles = 0;
    burst_left = 3;
    tracked_error = 0;
    integral_q16 = 0;
    active_cfg = '0;
    active_cfg.wrap_period = 32'(WRAP_PERIOD_RESET);

    // sel, action, setpoint, measured, typed, drive, error_seen
    dir_rows = '{
      // reset defaults: zero drive limit, error passes straight through
      '{0, 0, 0, 0, 1, 0, 0},
      '{0, 0, 8388607, -8388608, 1, 0, 16777215},
      '{0, 0, -8388608, 8388607, 1, 0, -16777215},
      '{0, 0, -8388608, -8388608, 1, 0, 0},
      '{0, 1, 8388607, -8388608, 1, 0, 0},
      '{0, 0, 5, -3, 1, 0, 8},
      // moderate gains, deadzone 100, wrap on at the default period
      '{1, 0, 99, 0, 0, 0, 0},
      '{1, 0, 0, 100, 0, 0, 0},
      '{1, 0, 64572, 0, 0, 0, 0},
      '{1, 0, 64573, 0, 0, 0, 0},
      '{1, 0, 0, 64572, 0, 0, 0},
      '{1, 0, 0, 64573, 0, 0, 0},
      '{1, 0, -8388608, 8388607, 0, 0, 0},
      '{1, 0, 1000, 3000, 0, 0, 0},
      '{1, 1, 0, 0, 0, 0, 0},
      '{1, 0, -7, 200, 0, 0, 0},
      // largest gains and limits, full deadzone, wrap with zero period
      '{2, 0, 8388607, -8388608, 0, 0, 0},
      '{2, 0, -8388608, 8388607, 0, 0, 0},
      '{2, 0, 8388607, -8388607, 0, 0, 0},
      '{2, 0, 0, 0, 0, 0, 0},
      // wrap with period one, zero integral limit
      '{3, 0, 1, 0, 0, 0, 0},
      '{3, 0, -1, 0, 0, 0, 0},
      '{3, 0, 0, 0, 0, 0, 0},
      '{3, 0, 8388607, -8388608, 0, 0, 0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    cur_sel = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_sel != cur_sel) begin
        wait_drained();
        cur_sel = dir_rows[i].cfg_sel;
        case (cur_sel)
          1: c = '{32'h0001_8000, 32'h0000_4000, 32'h0000_8000, 1000, 100000,
                   100, 1, 129144};
          2: c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h00FF_FFFF, 1, 0};
          default: c = '{32'h0001_0000, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF,
                         0, 1, 1};
        endcase
        apply_config(c);
      end
      k.typed = dir_rows[i].typed;
      k.res.drive = DRIVE_W'(dir_rows[i].exp_drive);
      k.res.err = ERR_W'(dir_rows[i].exp_err);
      offer(dir_rows[i].action, SAMPLE_WIDTH'(dir_rows[i].setpoint),
            SAMPLE_WIDTH'(dir_rows[i].measured), k);
    end

    // random phases, each under its own settings
    k = '0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      c.prop_gain = pick_gain();
      c.integ_gain = pick_gain();
      c.deriv_gain = pick_gain();
      c.integral_limit = pick_limit();
      c.drive_limit = pick_limit();
      case ($urandom_range(0, 4))
        0, 1: c.dead_band = 0;
        2, 3: c.dead_band = $urandom_range(0, 300);
        default: c.dead_band = $urandom_range(0, 32'h00FF_FFFF);
      endcase
      c.wrap_enable = $urandom_range(0, 1);
      case ($urandom_range(0, 5))
        0, 1, 2: c.wrap_period = 129144;
        3: c.wrap_period = $urandom_range(2, 32'h00FF_FFFF);
        4: c.wrap_period = $urandom_range(2, 1000);
        default: c.wrap_period = $urandom_range(0, 1);
      endcase
      // largest period once, with wrap on
      if (ph == 0) begin
        c.wrap_enable = 1;
        c.wrap_period = 32'h00FF_FFFF;
      end
      apply_config(c);
      sp = int'($urandom_range(0, 400000)) - 200000;
      ms = sp + int'($urandom_range(0, 20000)) - 10000;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 7))
          // measured walks toward a held setpoint
          0, 1, 2, 3: begin
            ms = ms + (sp - ms) / 8 + int'($urandom_range(0, 400)) - 200;
            offer($urandom_range(0, 24) == 0, SAMPLE_WIDTH'(sp), SAMPLE_WIDTH'(ms), k);
          end
          // error around the fold points
          4, 5: begin
            delta = int'(active_cfg.wrap_period / 2) + int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 1)) delta = -delta;
            offer($urandom_range(0, 24) == 0, SAMPLE_WIDTH'(sp),
                  SAMPLE_WIDTH'(sp - delta), k);
          end
          default: begin
            offer($urandom_range(0, 9) == 0, SAMPLE_WIDTH'($urandom),
                  SAMPLE_WIDTH'($urandom), k);
          end
        endcase
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("tb_positional_pid_deadzone_wrap passed");
    end else begin
      $display("tb_positional_pid_deadzone_wrap failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/ppid_pkg.sv
design/positional_pid_deadzone_wrap.sv
design/ppid_checker.sv
dv/tb_positional_pid_deadzone_wrap.sv
